### rtl/assert_macros.svh
// Assertion helpers for the RTL files that check their own behavior.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/fsge_pkg.sv
// Shared types, constants and defaults of the glyph strip extractor.
// No dependencies; every RTL module refers to it by scoped names.
package fsge_pkg;

    // default build parameters
    localparam int MAX_CELL_DEF    = 32;
    localparam int STRIP_BYTES_DEF = 16384;
    localparam int MAX_ROWS_DEF    = 32;

    // fixed sizes
    localparam int OFS_DEPTH  = 257;
    localparam int RES_CAP    = 32;
    localparam int OUT_BYTES  = 8;
    localparam int QDEPTH     = 4;
    localparam int RED_STEPS  = 7;
    localparam int RED_KW     = 3;
    localparam int S_TDATA_W  = 48;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 80;

    // input opcodes
    localparam logic [1:0] OP_WR_OFS   = 2'd0;
    localparam logic [1:0] OP_WR_STRIP = 2'd1;
    localparam logic [1:0] OP_RENDER   = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_FIRST_CHAR  = 3'd0;
    localparam logic [2:0] REG_LAST_CHAR   = 3'd1;
    localparam logic [2:0] REG_STRIP_ROW   = 3'd2;
    localparam logic [2:0] REG_FORM_ROWS   = 3'd3;
    localparam logic [2:0] REG_ROM_ROWS    = 3'd4;
    localparam logic [2:0] REG_OUT_STRIDE  = 3'd5;

    typedef enum logic [1:0] {
        K_WR_OFS,
        K_WR_STRIP,
        K_RENDER
    } kind_t;

    typedef struct packed {
        kind_t        kind;
        logic [13:0]  address;
        logic [15:0]  write_value;
        logic [15:0]  char_code;
    } item_t;

    typedef struct packed {
        logic [7:0]   first_char;
        logic [7:0]   last_char;
        logic [12:0]  strip_row_bytes;
        logic [5:0]   form_rows;
        logic [5:0]   rom_row_count;
        logic [3:0]   output_stride;
    } cfg_t;

    typedef struct packed {
        logic [4:0]   row_index;
        logic [63:0]  row_bits;
        logic [6:0]   glyph_width;
        logic         status;
        logic         last_row;
    } res_t;

    localparam cfg_t CFG_RESET = '{
        first_char:      8'd0,
        last_char:       8'd255,
        strip_row_bytes: 13'd256,
        form_rows:       6'd16,
        rom_row_count:   6'd0,
        output_stride:   4'd2
    };

endpackage

### rtl/font_strip_glyph_extract_core.sv
// Top level of the glyph strip extractor: configuration registers, front
// end, queue and back end. Depends on fsge_pkg, fsge_front, fsge_queue,
// fsge_back and assert_macros.svh.
//
// Usage:
//   Input transfers on s_axis carry writes to the bit-offset table, writes
//   to the strip store, and render requests (opcode in tuser). Writes give
//   no output. A render gives one transfer per glyph row on m_axis, with
//   tlast on the final row, or one error transfer (tuser = 1) when the
//   character is out of range, the glyph width is zero or too wide, or the
//   output stride is zero.
//   Configuration must be written through cfg_we/cfg_index/cfg_wdata only
//   while the block holds no work; the block itself does not enforce this.
// Sequence:
//   An offset write is done when the back end takes it; a strip write runs
//   through the 7-step address wrap unit. A render reads the offset table,
//   runs the address wrap twice (once in ROM mode), then reads each row one
//   byte at a time through the single strip memory read port, span bytes per
//   row, where span is the glyph's byte count (1 in ROM mode).
// Reset and stall:
//   Reset clears the configuration to its defaults and empties the queue
//   and output register; the stores hold garbage until written. A stalled
//   receiver holds the output register; the back end then waits, and the
//   four-entry queue keeps taking input until it fills.
`include "assert_macros.svh"

module font_strip_glyph_extract_core #(
    parameter int MAX_CELL    = fsge_pkg::MAX_CELL_DEF,
    parameter int STRIP_BYTES = fsge_pkg::STRIP_BYTES_DEF,
    parameter int MAX_ROWS    = fsge_pkg::MAX_ROWS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: address[13:0], write_value[29:14], char_code[45:30], zero pad
    input  logic [fsge_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // tuser: opcode[1:0]
    input  logic [fsge_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: row_index[4:0], row_bits[68:5], glyph_width[75:69], zero pad
    output logic [fsge_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // tuser: status[0]
    output logic                            m_axis_tuser,
    output logic                            m_axis_tlast,
    // configuration writes
    input  logic                            cfg_we,
    input  logic [2:0]                      cfg_index,
    input  logic [12:0]                     cfg_wdata
);

    fsge_pkg::cfg_t   cfg_reg;
    logic             q_push;
    fsge_pkg::item_t  push_item;
    logic             q_ready;
    logic             q_valid;
    fsge_pkg::item_t  q_item;
    logic             q_pop;
    fsge_pkg::res_t   out_res;

    // configuration registers; writes to unused indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= fsge_pkg::CFG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fsge_pkg::REG_FIRST_CHAR: cfg_reg.first_char      <= cfg_wdata[7:0];
                fsge_pkg::REG_LAST_CHAR:  cfg_reg.last_char       <= cfg_wdata[7:0];
                fsge_pkg::REG_STRIP_ROW:  cfg_reg.strip_row_bytes <= cfg_wdata;
                fsge_pkg::REG_FORM_ROWS:  cfg_reg.form_rows       <= cfg_wdata[5:0];
                fsge_pkg::REG_ROM_ROWS:   cfg_reg.rom_row_count   <= cfg_wdata[5:0];
                fsge_pkg::REG_OUT_STRIDE: cfg_reg.output_stride   <= cfg_wdata[3:0];
                default:                  cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // accept and classify each transfer
    fsge_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_opcode  (s_axis_tuser),
        .in_address (s_axis_tdata[13:0]),
        .in_value   (s_axis_tdata[29:14]),
        .in_char    (s_axis_tdata[45:30]),
        .push       (q_push),
        .push_item  (push_item),
        .q_ready    (q_ready)
    );

    // hold classified items until the back end is free
    fsge_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .q_ready   (q_ready),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (q_pop)
    );

    // carry out writes and renders in arrival order
    fsge_back #(
        .MAX_CELL    (MAX_CELL),
        .STRIP_BYTES (STRIP_BYTES),
        .MAX_ROWS    (MAX_ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (q_pop),
        .out_valid (m_axis_tvalid),
        .out_res   (out_res),
        .out_ready (m_axis_tready)
    );

    assign m_axis_tdata = {4'd0, out_res.glyph_width, out_res.row_bits, out_res.row_index};
    assign m_axis_tuser = out_res.status;
    assign m_axis_tlast = out_res.last_row;

    // an error transfer is a single, empty, final result
    `ASSERT_IMPL(a_err_shape, m_axis_tvalid && m_axis_tuser, m_axis_tlast && (m_axis_tdata == '0), "error result not empty and final")
    // ROM-mode rows always report eight columns
    `ASSERT_IMPL(a_rom_width, m_axis_tvalid && !m_axis_tuser && (cfg_reg.rom_row_count != '0), m_axis_tdata[75:69] == 7'd8, "ROM row width not 8")
    // the front never pushes into a full queue
    `ASSERT_CLK(a_q_room, !q_push || q_ready, "push into full queue")

endmodule

### rtl/fsge_front.sv
// Front end: accepts input transfers, drops items that do nothing and
// tags the rest with their kind. Depends on fsge_pkg.
module fsge_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [fsge_pkg::S_TUSER_W-1:0]  in_opcode,
    input  logic [13:0]                     in_address,
    input  logic [15:0]                     in_value,
    input  logic [15:0]                     in_char,
    output logic                            push,
    output fsge_pkg::item_t                 push_item,
    input  logic                            q_ready
);

    logic             f_valid_reg;
    logic             f_valid_next;
    fsge_pkg::item_t  f_item_reg;
    fsge_pkg::item_t  f_item_next;
    logic             keep;
    fsge_pkg::kind_t  kind;

    assign in_ready  = !f_valid_reg || q_ready;
    assign push      = f_valid_reg && q_ready;
    assign push_item = f_item_reg;

    always_comb
    begin
        keep = 1'b0;
        kind = fsge_pkg::K_RENDER;
        unique case (in_opcode)
            fsge_pkg::OP_WR_OFS:
            begin
                kind = fsge_pkg::K_WR_OFS;
                keep = (in_address < 14'(fsge_pkg::OFS_DEPTH));
            end
            fsge_pkg::OP_WR_STRIP:
            begin
                kind = fsge_pkg::K_WR_STRIP;
                keep = 1'b1;
            end
            fsge_pkg::OP_RENDER:
            begin
                kind = fsge_pkg::K_RENDER;
                keep = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        f_valid_next = f_valid_reg;
        f_item_next  = f_item_reg;
        if (in_valid && in_ready)
        begin
            f_valid_next = keep;
            f_item_next  = '{kind: kind, address: in_address,
                             write_value: in_value, char_code: in_char};
        end
        else if (push)
        begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
            f_item_reg  <= f_item_next;
        end
    end

endmodule

### rtl/fsge_queue.sv
// Short queue between front and back end, so each side can stall alone.
// Depends on fsge_pkg.
module fsge_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  fsge_pkg::item_t  push_item,
    output logic             q_ready,
    output logic             q_valid,
    output fsge_pkg::item_t  q_item,
    input  logic             pop
);

    localparam int QAW = $clog2(fsge_pkg::QDEPTH);

    fsge_pkg::item_t  mem [0:fsge_pkg::QDEPTH-1];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QAW:0]     count_reg;

    assign q_ready = (count_reg != (QAW+1)'(fsge_pkg::QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

### rtl/fsge_back.sv
// Back end: holds the offset table and strip store, runs writes and renders
// row by row into an output register. Depends on fsge_pkg.
module fsge_back #(
    parameter int MAX_CELL    = fsge_pkg::MAX_CELL_DEF,
    parameter int STRIP_BYTES = fsge_pkg::STRIP_BYTES_DEF,
    parameter int MAX_ROWS    = fsge_pkg::MAX_ROWS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  fsge_pkg::cfg_t   cfg,
    input  logic             q_valid,
    input  fsge_pkg::item_t  q_item,
    output logic             pop,
    output logic             out_valid,
    output fsge_pkg::res_t   out_res,
    input  logic             out_ready
);

    localparam int AW      = $clog2(STRIP_BYTES);
    localparam int RED_W   = AW + fsge_pkg::RED_STEPS;
    localparam int OFS_AW  = $clog2(fsge_pkg::OFS_DEPTH);
    localparam int BUF_N   = fsge_pkg::OUT_BYTES + 1;
    localparam int BUF_IW  = $clog2(BUF_N);
    localparam int SPAN_W  = $clog2((MAX_CELL + 14) / 8 + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_OFS,
        S_ROW,
        S_EMIT,
        S_ERR
    } state_t;

    typedef enum logic [1:0] {
        T_WRITE,
        T_SRB,
        T_START,
        T_ROM
    } tgt_t;

    // stores
    logic [15:0]  ofs_mem   [0:fsge_pkg::OFS_DEPTH-1];
    logic [7:0]   strip_mem [0:STRIP_BYTES-1];
    logic [15:0]  ofs_rd0_reg;
    logic [15:0]  ofs_rd1_reg;
    logic [7:0]   strip_rd_reg;
    logic [OFS_AW-1:0] ofs_raddr0;
    logic [OFS_AW-1:0] ofs_raddr1;
    logic         ofs_we;
    logic         strip_we;

    // sequencer state
    state_t                     state_reg, state_next;
    tgt_t                       tgt_reg, tgt_next;
    logic [RED_W-1:0]           red_reg, red_next;
    logic [fsge_pkg::RED_KW-1:0] red_k_reg, red_k_next;
    logic [7:0]                 wr_byte_reg, wr_byte_next;
    logic [12:0]                start_reg, start_next;
    logic [AW-1:0]              srbm_reg, srbm_next;
    logic [AW-1:0]              rowbase_reg, rowbase_next;
    logic [AW-1:0]              byte_addr_reg, byte_addr_next;
    logic [2:0]                 shift_reg, shift_next;
    logic [SPAN_W-1:0]          span_reg, span_next;
    logic [6:0]                 width_reg, width_next;
    logic                       rom_reg, rom_next;
    logic [3:0]                 stride_reg, stride_next;
    logic [4:0]                 rows_m1_reg, rows_m1_next;
    logic [4:0]                 row_reg, row_next;
    logic [SPAN_W-1:0]          iss_reg, iss_next;
    logic [BUF_IW-1:0]          cap_reg, cap_next;
    logic                       pend_reg, pend_next;
    logic [7:0]                 buf_reg [0:BUF_N-1];
    logic                       out_valid_reg, out_valid_next;
    fsge_pkg::res_t             out_reg, out_next;

    // helpers
    logic [15:0]       ch;
    logic              in_range;
    logic              rom_mode;
    logic [6:0]        nrows;
    logic [3:0]        stride_eff;
    logic [RED_W-1:0]  red_sub;
    logic [RED_W-1:0]  red_after;
    logic [AW:0]       row_sum;
    logic [AW-1:0]     row_adv;
    logic [AW-1:0]     byte_adv;
    logic [15:0]       gl_width;
    logic [6:0]        gl_span;
    logic              out_free;
    logic              row_ok;
    logic [63:0]       row_bits;
    logic [7:0]        nxt_byte;
    logic [15:0]       pair;

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign pop       = (state_reg == S_IDLE) && q_valid;

    assign ch         = q_item.char_code;
    assign in_range   = (ch >= {8'd0, cfg.first_char}) && (ch <= {8'd0, cfg.last_char});
    assign rom_mode   = (cfg.rom_row_count != '0);
    assign stride_eff = (cfg.output_stride > 4'd8) ? 4'd8 : cfg.output_stride;
    assign ofs_raddr0 = {1'b0, ch[7:0] - cfg.first_char};
    assign ofs_raddr1 = ofs_raddr0 + 1'b1;

    // row count: form rows, grown to the ROM row count in ROM mode, at least one, then capped
    always_comb
    begin
        nrows = {1'b0, cfg.form_rows};
        if (rom_mode && (cfg.rom_row_count > cfg.form_rows))
        begin
            nrows = {1'b0, cfg.rom_row_count};
        end
        if (nrows == '0)
        begin
            nrows = 7'd1;
        end
        if (nrows > 7'(MAX_ROWS))
        begin
            nrows = 7'(MAX_ROWS);
        end
        if (nrows > 7'(fsge_pkg::RES_CAP))
        begin
            nrows = 7'(fsge_pkg::RES_CAP);
        end
    end

    // one step of the modulo reduction: subtract the store size shifted up
    assign red_sub   = RED_W'(STRIP_BYTES) << red_k_reg;
    assign red_after = (red_reg >= red_sub) ? (red_reg - red_sub) : red_reg;

    assign row_sum  = {1'b0, rowbase_reg} + {1'b0, srbm_reg};
    assign row_adv  = (row_sum >= (AW+1)'(STRIP_BYTES))
                    ? AW'(row_sum - (AW+1)'(STRIP_BYTES)) : row_sum[AW-1:0];
    assign byte_adv = (byte_addr_reg == AW'(STRIP_BYTES - 1)) ? '0 : byte_addr_reg + 1'b1;

    assign gl_width = ofs_rd1_reg - ofs_rd0_reg;
    assign gl_span  = ({4'd0, ofs_rd0_reg[2:0]} + gl_width[6:0] + 7'd7) >> 3;

    assign row_ok = !rom_reg || ({1'b0, row_reg} < cfg.rom_row_count);

    // align the row so the first glyph column lands in bit 7 of byte 0
    always_comb
    begin
        row_bits = '0;
        nxt_byte = '0;
        pair     = '0;
        for (int i = 0; i < fsge_pkg::OUT_BYTES; i++)
        begin
            nxt_byte = ((i + 1) < int'(span_reg)) ? buf_reg[i+1] : 8'd0;
            pair     = {buf_reg[i], nxt_byte} << shift_reg;
            if (row_ok && (i < int'(stride_reg)) && (i < int'(span_reg)))
            begin
                row_bits[8*i +: 8] = pair[15:8];
            end
        end
    end

    assign ofs_we   = pop && (q_item.kind == fsge_pkg::K_WR_OFS);
    assign strip_we = (state_reg == S_RED) && (red_k_reg == '0) && (tgt_reg == T_WRITE);

    always_ff @(posedge clk)
    begin
        if (ofs_we)
        begin
            ofs_mem[q_item.address[OFS_AW-1:0]] <= q_item.write_value;
        end
        ofs_rd0_reg <= ofs_mem[ofs_raddr0];
        ofs_rd1_reg <= ofs_mem[ofs_raddr1];
    end

    always_ff @(posedge clk)
    begin
        if (strip_we)
        begin
            strip_mem[red_after[AW-1:0]] <= wr_byte_reg;
        end
        strip_rd_reg <= strip_mem[byte_addr_reg];
    end

    always_comb
    begin
        state_next     = state_reg;
        tgt_next       = tgt_reg;
        red_next       = red_reg;
        red_k_next     = red_k_reg;
        wr_byte_next   = wr_byte_reg;
        start_next     = start_reg;
        srbm_next      = srbm_reg;
        rowbase_next   = rowbase_reg;
        byte_addr_next = byte_addr_reg;
        shift_next     = shift_reg;
        span_next      = span_reg;
        width_next     = width_reg;
        rom_next       = rom_reg;
        stride_next    = stride_reg;
        rows_m1_next   = rows_m1_reg;
        row_next       = row_reg;
        iss_next       = iss_reg;
        cap_next       = cap_reg;
        pend_next      = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_item.kind)
                        fsge_pkg::K_WR_OFS:
                        begin
                            state_next = S_IDLE;
                        end
                        fsge_pkg::K_WR_STRIP:
                        begin
                            red_next     = RED_W'(q_item.address);
                            wr_byte_next = q_item.write_value[7:0];
                            tgt_next     = T_WRITE;
                            red_k_next   = fsge_pkg::RED_KW'(fsge_pkg::RED_STEPS - 1);
                            state_next   = S_RED;
                        end
                        default:
                        begin
                            rows_m1_next = 5'(nrows - 7'd1);
                            stride_next  = stride_eff;
                            rom_next     = rom_mode;
                            row_next     = '0;
                            if (cfg.output_stride == '0)
                            begin
                                state_next = S_ERR;
                            end
                            else if (rom_mode)
                            begin
                                if (ch > 16'd255)
                                begin
                                    state_next = S_ERR;
                                end
                                else
                                begin
                                    red_next   = RED_W'(ch[7:0] * cfg.rom_row_count);
                                    srbm_next  = AW'(1);
                                    shift_next = '0;
                                    span_next  = SPAN_W'(1);
                                    width_next = 7'd8;
                                    tgt_next   = T_ROM;
                                    red_k_next = fsge_pkg::RED_KW'(fsge_pkg::RED_STEPS - 1);
                                    state_next = S_RED;
                                end
                            end
                            else if (!in_range)
                            begin
                                state_next = S_ERR;
                            end
                            else
                            begin
                                state_next = S_OFS;
                            end
                        end
                    endcase
                end
            end

            S_OFS:
            begin
                if ((gl_width == '0) || (gl_width > 16'(MAX_CELL)))
                begin
                    state_next = S_ERR;
                end
                else
                begin
                    shift_next = ofs_rd0_reg[2:0];
                    start_next = ofs_rd0_reg[15:3];
                    width_next = gl_width[6:0];
                    span_next  = SPAN_W'(gl_span);
                    red_next   = RED_W'(cfg.strip_row_bytes);
                    tgt_next   = T_SRB;
                    red_k_next = fsge_pkg::RED_KW'(fsge_pkg::RED_STEPS - 1);
                    state_next = S_RED;
                end
            end

            S_RED:
            begin
                red_next   = red_after;
                red_k_next = red_k_reg - 1'b1;
                if (red_k_reg == '0)
                begin
                    unique case (tgt_reg)
                        T_WRITE:
                        begin
                            state_next = S_IDLE;
                        end
                        T_SRB:
                        begin
                            srbm_next  = red_after[AW-1:0];
                            red_next   = RED_W'(start_reg);
                            tgt_next   = T_START;
                            red_k_next = fsge_pkg::RED_KW'(fsge_pkg::RED_STEPS - 1);
                        end
                        default:
                        begin
                            rowbase_next   = red_after[AW-1:0];
                            byte_addr_next = red_after[AW-1:0];
                            iss_next       = '0;
                            cap_next       = '0;
                            state_next     = S_ROW;
                        end
                    endcase
                end
            end

            S_ROW:
            begin
                // capture the byte read last cycle, issue the next one
                if (pend_reg)
                begin
                    cap_next = cap_reg + 1'b1;
                end
                if (iss_reg < span_reg)
                begin
                    byte_addr_next = byte_adv;
                    iss_next       = iss_reg + 1'b1;
                    pend_next      = 1'b1;
                end
                else if (!pend_reg)
                begin
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next = '{row_index: row_reg, row_bits: row_bits,
                                 glyph_width: width_reg, status: 1'b0,
                                 last_row: (row_reg == rows_m1_reg)};
                    row_next = row_reg + 1'b1;
                    if (row_reg == rows_m1_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rowbase_next   = row_adv;
                        byte_addr_next = row_adv;
                        iss_next       = '0;
                        cap_next       = '0;
                        state_next     = S_ROW;
                    end
                end
            end

            S_ERR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next = '{row_index: '0, row_bits: '0, glyph_width: '0,
                                 status: 1'b1, last_row: 1'b1};
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            red_k_reg     <= '0;
            iss_reg       <= '0;
            cap_reg       <= '0;
            pend_reg      <= 1'b0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tgt_reg       <= tgt_next;
            red_reg       <= red_next;
            red_k_reg     <= red_k_next;
            wr_byte_reg   <= wr_byte_next;
            start_reg     <= start_next;
            srbm_reg      <= srbm_next;
            rowbase_reg   <= rowbase_next;
            byte_addr_reg <= byte_addr_next;
            shift_reg     <= shift_next;
            span_reg      <= span_next;
            width_reg     <= width_next;
            rom_reg       <= rom_next;
            stride_reg    <= stride_next;
            rows_m1_reg   <= rows_m1_next;
            row_reg       <= row_next;
            iss_reg       <= iss_next;
            cap_reg       <= cap_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
            if ((state_reg == S_ROW) && pend_reg)
            begin
                buf_reg[cap_reg] <= strip_rd_reg;
            end
        end
    end

endmodule
